>>> src/gbba_pkg.sv
// Shared constants and types for the group bitmap block allocator.
package gbba_pkg;

  // Request kinds carried on s_tuser
  localparam logic [1:0] KIND_LOAD_WORD  = 2'd0;
  localparam logic [1:0] KIND_LOAD_GROUP = 2'd1;
  localparam logic [1:0] KIND_LOAD_TOTAL = 2'd2;
  localparam logic [1:0] KIND_ALLOCATE   = 2'd3;

  // Configuration register indexes (byte address is four times the index)
  localparam logic [1:0] REG_GROUPS_IN_USE    = 2'd0;
  localparam logic [1:0] REG_BITS_PER_BITMAP  = 2'd1;
  localparam logic [1:0] REG_BLOCKS_PER_GROUP = 2'd2;
  localparam logic [1:0] REG_FIRST_DATA_BLOCK = 2'd3;

  // Field widths
  localparam int KIND_W   = 2;
  localparam int GROUP_W  = 4;
  localparam int WIDX_W   = 7;
  localparam int VALUE_W  = 64;
  localparam int GIU_W    = 5;
  localparam int NBITS_W  = 14;
  localparam int BPG_W    = 14;
  localparam int COUNT_W  = 14;
  localparam int BLOCK_W  = 18;
  localparam int TOTAL_W  = 18;

  // Stream and register port widths
  localparam int S_TDATA_W = 80;
  localparam int S_TUSER_W = KIND_W;
  localparam int M_TDATA_W = 40;
  localparam int M_TUSER_W = 1;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  // Register reset values
  localparam logic [GIU_W-1:0]   GIU_RESET   = 5'd16;
  localparam logic [NBITS_W-1:0] NBITS_RESET = 14'd8192;
  localparam logic [BPG_W-1:0]   BPG_RESET   = 14'd8192;

  // Status codes
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_NO_SPACE = 1'b1;

  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [TOTAL_W-1:0] total_t;
  typedef logic [BLOCK_W-1:0] block_t;

endpackage

>>> src/group_bitmap_block_allocator.sv
// Group bitmap block allocator: bitmap memory, group counters and first-fit scan.
//
// Usage: requests arrive on the s_ stream (kind on s_tuser, group, word index
// and load value on s_tdata); every request gives exactly one result on the
// m_ stream (status on m_tuser, block number and total free count on m_tdata).
// Loads fill bitmap words, group free counters or the total free counter;
// back-to-back loads are taken every cycle while the receiver keeps up.
// An allocate request scans groups in order from group 0, reading one
// bitmap word per cycle from the read port of the bitmap memory; a group
// with a zero counter or an exhausted word range is passed over. One
// request is worked on at a time; s_tready is high whenever the block is
// idle, also while a finished result waits in the output register. When
// the receiver stalls, the result is held in the output register and a
// later result waits in the block until it drains. Reset (synchronous,
// active high) clears the total free counter and the handshake state and
// returns the configuration registers to their defaults; the bitmap memory
// and group counters hold nothing defined until loaded. Configuration must
// be written through the APB port only while the block is idle; the block
// itself does not enforce this.
module group_bitmap_block_allocator #(
  parameter int MAX_GROUPS         = 16,
  parameter int MAX_BITS_PER_GROUP = 8192,
  parameter int WORD_BITS          = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  // Request stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // s_tdata: group [3:0], word_index [10:4], load_value [74:11], zero [79:75]
  input  logic [gbba_pkg::S_TDATA_W-1:0]   s_tdata,
  // s_tuser: kind [1:0]
  input  logic [gbba_pkg::S_TUSER_W-1:0]   s_tuser,
  // Result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // m_tdata: block_number [17:0], free_remaining [35:18], zero [39:36]
  output logic [gbba_pkg::M_TDATA_W-1:0]   m_tdata,
  // m_tuser: status [0]
  output logic [gbba_pkg::M_TUSER_W-1:0]   m_tuser,
  // Configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [gbba_pkg::PADDR_W-1:0]     paddr,
  input  logic [gbba_pkg::PDATA_W-1:0]     pwdata,
  output logic [gbba_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);
  import gbba_pkg::*;

  localparam int WPG    = MAX_BITS_PER_GROUP / WORD_BITS;
  localparam int DEPTH  = MAX_GROUPS * WPG;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int G_IDX  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int GC_W   = $clog2(MAX_GROUPS + 1);
  localparam int WI_W   = (WPG > 1) ? $clog2(WPG) : 1;
  localparam int SW_W   = $clog2(WPG + 1);
  localparam int LOG_WB = $clog2(WORD_BITS);
  localparam int BP_W   = (LOG_WB > 0) ? LOG_WB : 1;
  localparam int NB_W   = $clog2(MAX_BITS_PER_GROUP + 1) > NBITS_W ?
                          $clog2(MAX_BITS_PER_GROUP + 1) : NBITS_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_HIT  = 3'd2;
  localparam logic [2:0] ST_SUM  = 3'd3;
  localparam logic [2:0] ST_PUT  = 3'd4;

  // Configuration registers
  logic [GIU_W-1:0]   groups_in_use;
  logic [NBITS_W-1:0] bits_per_bitmap;
  logic [BPG_W-1:0]   group_stride;
  logic               block_offset;

  // State
  logic [WORD_BITS-1:0] mem [DEPTH];
  count_t               gcount [MAX_GROUPS];
  total_t               total_free;
  logic [2:0]           state;

  // Scan control
  logic [GC_W-1:0]      scan_g;
  logic [SW_W-1:0]      scan_w;
  logic                 rd_pend;
  logic [G_IDX-1:0]     rd_g;
  logic [WI_W-1:0]      rd_w;
  logic [WORD_BITS-1:0] rd_data;

  // Hit and result holding
  logic [G_IDX-1:0]       hit_g;
  logic [WI_W-1:0]        hit_w;
  logic [BP_W-1:0]        hit_bit;
  logic [WORD_BITS-1:0]   hit_word;
  logic [G_IDX+BPG_W-1:0] prod;
  logic                   res_status;
  block_t                 res_block;
  total_t                 res_free;

  // Output register
  logic   out_status;
  block_t out_blockno;
  total_t out_free;

  // Request fields
  logic [KIND_W-1:0]  in_kind;
  logic [GROUP_W-1:0] in_group;
  logic [WIDX_W-1:0]  in_widx;
  logic [VALUE_W-1:0] in_value;

  logic                 accept;
  logic                 out_free_slot;
  logic                 out_load;
  logic                 grp_ok;
  logic                 widx_ok;
  total_t               total_new;
  logic [GC_W-1:0]      ng;
  logic [NB_W-1:0]      nbits;
  logic [G_IDX-1:0]     g_idx;
  logic                 grp_end;
  logic [NB_W-1:0]      word_base;
  logic                 word_out;
  logic                 issue;
  logic [ADDR_W-1:0]    rd_addr;
  logic [NB_W-1:0]      rd_base;
  logic [NB_W-1:0]      rem;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] cand;
  logic                 rd_hit;
  logic [BP_W-1:0]      cand_pos;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 cfg_we;

  assign in_kind  = s_tuser[KIND_W-1:0];
  assign in_group = s_tdata[GROUP_W-1:0];
  assign in_widx  = s_tdata[GROUP_W+WIDX_W-1:GROUP_W];
  assign in_value = s_tdata[GROUP_W+WIDX_W+VALUE_W-1:GROUP_W+WIDX_W];

  assign s_tready      = (state == ST_IDLE);
  assign accept        = s_tvalid && s_tready;
  assign out_free_slot = !m_tvalid || m_tready;

  // Load the output register with a load result or a finished scan
  assign out_load = out_free_slot &&
                    ((accept && in_kind != KIND_ALLOCATE) || (state == ST_PUT));

  assign m_tdata = {{(M_TDATA_W - BLOCK_W - TOTAL_W){1'b0}}, out_free, out_blockno};
  assign m_tuser = out_status;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      REG_GROUPS_IN_USE:    prdata = PDATA_W'(groups_in_use);
      REG_BITS_PER_BITMAP:  prdata = PDATA_W'(bits_per_bitmap);
      REG_BLOCKS_PER_GROUP: prdata = PDATA_W'(group_stride);
      REG_FIRST_DATA_BLOCK: prdata = PDATA_W'(block_offset);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      groups_in_use   <= GIU_RESET;
      bits_per_bitmap <= NBITS_RESET;
      group_stride    <= BPG_RESET;
      block_offset    <= 1'b1;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_GROUPS_IN_USE:    groups_in_use   <= pwdata[GIU_W-1:0];
        REG_BITS_PER_BITMAP:  bits_per_bitmap <= pwdata[NBITS_W-1:0];
        REG_BLOCKS_PER_GROUP: group_stride    <= pwdata[BPG_W-1:0];
        REG_FIRST_DATA_BLOCK: block_offset    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Saturate the scan limits to the stored sizes
  assign ng    = (32'(groups_in_use) > 32'(MAX_GROUPS)) ? GC_W'(MAX_GROUPS)
                                                        : GC_W'(groups_in_use);
  assign nbits = (32'(bits_per_bitmap) > 32'(MAX_BITS_PER_GROUP)) ?
                 NB_W'(MAX_BITS_PER_GROUP) : NB_W'(bits_per_bitmap);

  // Load checks
  assign grp_ok    = 32'(in_group) < 32'(MAX_GROUPS);
  assign widx_ok   = 32'(in_widx) < 32'(WPG);
  assign total_new = (accept && in_kind == KIND_LOAD_TOTAL) ? in_value[TOTAL_W-1:0]
                                                            : total_free;

  // Issue side of the scan: pass empty groups and exhausted word ranges
  assign g_idx     = scan_g[G_IDX-1:0];
  assign grp_end   = scan_g >= ng;
  assign word_base = NB_W'(scan_w) << LOG_WB;
  assign word_out  = (32'(scan_w) == 32'(WPG)) || (word_base >= nbits) ||
                     (gcount[g_idx] == '0);
  assign issue     = (state == ST_SCAN) && !grp_end && !word_out;
  assign rd_addr   = ADDR_W'(32'(g_idx) * 32'(WPG) + 32'(scan_w[WI_W-1:0]));

  // Evaluate side: look for the lowest clear bit in range
  assign rd_base = NB_W'(rd_w) << LOG_WB;
  assign rem     = nbits - rd_base;
  always_comb begin
    if (32'(rem) >= 32'(WORD_BITS)) begin
      mask = '1;
    end else begin
      mask = (WORD_BITS'(1) << rem) - WORD_BITS'(1);
    end
  end
  assign cand   = ~rd_data & mask;
  assign rd_hit = rd_pend && (cand != '0);

  always_comb begin
    cand_pos = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (cand[b]) begin
        cand_pos = BP_W'(b);
      end
    end
  end

  // Bitmap memory write port: loads and the allocation write-back
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ADDR_W'(32'(hit_g) * 32'(WPG) + 32'(hit_w));
    mem_wdata = hit_word | (WORD_BITS'(1) << hit_bit);
    if (state == ST_HIT) begin
      mem_we = 1'b1;
    end else if (accept && in_kind == KIND_LOAD_WORD && grp_ok && widx_ok) begin
      mem_we    = 1'b1;
      mem_waddr = ADDR_W'(32'(in_group) * 32'(WPG) + 32'(in_widx));
      mem_wdata = in_value[WORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Group counters: load and decrement on allocation
  always_ff @(posedge clk) begin
    if (state == ST_HIT) begin
      gcount[hit_g] <= gcount[hit_g] - count_t'(1);
    end else if (accept && in_kind == KIND_LOAD_GROUP && grp_ok) begin
      gcount[G_IDX'(in_group)] <= in_value[COUNT_W-1:0];
    end
  end

  // Scan payload: read tags, hit capture and result forming
  always_ff @(posedge clk) begin
    rd_g <= g_idx;
    rd_w <= scan_w[WI_W-1:0];
    if (state == ST_SCAN && rd_hit) begin
      hit_g    <= rd_g;
      hit_w    <= rd_w;
      hit_bit  <= cand_pos;
      hit_word <= rd_data;
    end
    if (state == ST_HIT) begin
      prod <= (G_IDX+BPG_W)'(hit_g) * (G_IDX+BPG_W)'(group_stride);
    end
    if (state == ST_SUM) begin
      res_status <= STATUS_OK;
      res_block  <= BLOCK_W'(32'(block_offset) + 32'(prod) +
                            32'({hit_w, hit_bit}));
      res_free   <= total_free;
    end else if (state == ST_SCAN && !rd_hit && grp_end && !rd_pend) begin
      res_status <= STATUS_NO_SPACE;
      res_block  <= '0;
      res_free   <= total_free;
    end else if (accept && in_kind != KIND_ALLOCATE) begin
      res_status <= STATUS_OK;
      res_block  <= '0;
      res_free   <= total_new;
    end
  end

  // Control: state, scan pointers, total counter and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      scan_g      <= '0;
      scan_w      <= '0;
      rd_pend     <= 1'b0;
      total_free  <= '0;
      m_tvalid    <= 1'b0;
      out_status  <= STATUS_OK;
      out_blockno <= '0;
      out_free    <= '0;
    end else begin
      // Raise the result when the output register is loaded, drop it once taken
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            total_free <= total_new;
            if (in_kind == KIND_ALLOCATE) begin
              scan_g  <= '0;
              scan_w  <= '0;
              rd_pend <= 1'b0;
              state   <= ST_SCAN;
            end else if (out_free_slot) begin
              out_status  <= STATUS_OK;
              out_blockno <= '0;
              out_free    <= total_new;
            end else begin
              state <= ST_PUT;
            end
          end
        end
        ST_SCAN: begin
          rd_pend <= issue;
          if (rd_hit) begin
            rd_pend <= 1'b0;
            state   <= ST_HIT;
          end else if (grp_end && !rd_pend) begin
            state <= ST_PUT;
          end else if (!grp_end) begin
            if (word_out) begin
              scan_g <= scan_g + GC_W'(1);
              scan_w <= '0;
            end else begin
              scan_w <= scan_w + SW_W'(1);
            end
          end
        end
        ST_HIT: begin
          if (total_free != '0) begin
            total_free <= total_free - total_t'(1);
          end
          state <= ST_SUM;
        end
        ST_SUM: begin
          state <= ST_PUT;
        end
        ST_PUT: begin
          if (out_free_slot) begin
            out_status  <= res_status;
            out_blockno <= res_block;
            out_free    <= res_free;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sim/group_bitmap_block_allocator_tb.sv
// Self-checking testbench for the group bitmap block allocator stream and register ports.
`timescale 1ns / 1ps

module group_bitmap_block_allocator_tb;
  import gbba_pkg::*;

  localparam int MAP_GROUPS      = 16;
  localparam int MAP_WORD_BITS   = 64;
  localparam int MAP_BITS        = 8192;
  localparam int WORDS_PER_GROUP = MAP_BITS / MAP_WORD_BITS;
  localparam int SETTLE_CYCLES   = 8;
  localparam int STALL_LIMIT     = 30000;

  typedef enum logic [1:0] {FIT_FOUND, FIT_NONE, FIT_UNLOADED} fit_t;

  typedef struct packed {
    logic   status;
    block_t block;
    total_t free_left;
  } alloc_result_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic [S_TUSER_W-1:0] s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [M_TUSER_W-1:0] m_tuser;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  // Predicted allocator state and registers
  logic [MAP_WORD_BITS-1:0] map_word   [MAP_GROUPS*WORDS_PER_GROUP];
  bit                       map_loaded [MAP_GROUPS*WORDS_PER_GROUP];
  count_t                   grp_free   [MAP_GROUPS];
  bit                       grp_loaded [MAP_GROUPS];
  total_t                   free_total;
  logic [GIU_W-1:0]         cfg_groups;
  logic [NBITS_W-1:0]       cfg_bits;
  logic [BPG_W-1:0]         cfg_stride;
  logic                     cfg_offset;

  alloc_result_t awaited_results[$];
  int            error_count  = 0;
  int            items_sent   = 0;
  int            quiet_cycles = 0;
  int            full_pct     = 50;
  bit            steady       = 1'b0;

  group_bitmap_block_allocator u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #10 clk = ~clk;

  // First-fit scan over the predicted state; also reports the first entry the
  // scan would read before it was ever loaded
  function automatic fit_t first_fit(output int fg, output int fpos,
                                     output int gap_g, output int gap_w);
    int ng;
    int nb;
    logic [MAP_WORD_BITS-1:0] word;
    fg    = 0;
    fpos  = 0;
    gap_g = 0;
    gap_w = -1;
    ng = (cfg_groups > MAP_GROUPS) ? MAP_GROUPS : int'(cfg_groups);
    nb = (cfg_bits > MAP_BITS) ? MAP_BITS : int'(cfg_bits);
    for (int g = 0; g < ng; g++) begin
      if (!grp_loaded[g]) begin
        gap_g = g;
        return FIT_UNLOADED;
      end
      if (grp_free[g] == 0) continue;
      for (int w = 0; w < WORDS_PER_GROUP && w * MAP_WORD_BITS < nb; w++) begin
        if (!map_loaded[g*WORDS_PER_GROUP + w]) begin
          gap_g = g;
          gap_w = w;
          return FIT_UNLOADED;
        end
        word = map_word[g*WORDS_PER_GROUP + w];
        if (&word) continue;
        for (int b = 0; b < MAP_WORD_BITS && w * MAP_WORD_BITS + b < nb; b++) begin
          if (!word[b]) begin
            fg   = g;
            fpos = w * MAP_WORD_BITS + b;
            return FIT_FOUND;
          end
        end
      end
    end
    return FIT_NONE;
  endfunction

  // Apply one accepted request to the predicted state and queue its result
  task automatic predict_request(input logic [1:0] kind, input int grp, input int widx,
                                 input logic [63:0] value);
    alloc_result_t r;
    fit_t          fit;
    int            fg, fpos, gg, gw;
    r = '0;
    case (kind)
      KIND_LOAD_WORD: begin
        map_word[grp*WORDS_PER_GROUP + widx]   = value;
        map_loaded[grp*WORDS_PER_GROUP + widx] = 1'b1;
      end
      KIND_LOAD_GROUP: begin
        grp_free[grp]   = value[COUNT_W-1:0];
        grp_loaded[grp] = 1'b1;
      end
      KIND_LOAD_TOTAL: begin
        free_total = value[TOTAL_W-1:0];
      end
      default: begin
        fit = first_fit(fg, fpos, gg, gw);
        if (fit == FIT_FOUND) begin
          map_word[fg*WORDS_PER_GROUP + fpos/MAP_WORD_BITS][fpos%MAP_WORD_BITS] = 1'b1;
          grp_free[fg] = grp_free[fg] - 1'b1;
          if (free_total != 0) free_total = free_total - 1'b1;
          r.block = block_t'(int'(cfg_offset) + fg * int'(cfg_stride) + fpos);
        end else begin
          r.status = STATUS_NO_SPACE;
        end
      end
    endcase
    r.free_left = free_total;
    awaited_results.push_back(r);
  endtask

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  // Offer one request, hold it until accepted, then predict its result
  task automatic send_request(input logic [1:0] kind, input int grp, input int widx,
                              input logic [63:0] value);
    bit taken;
    while (!steady && $urandom_range(99) < 10) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {5'b0, value, widx[WIDX_W-1:0], grp[GROUP_W-1:0]};
    do begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end while (!taken);
    items_sent++;
    predict_request(kind, grp, widx, value);
  endtask

  // Hold off the sender until every awaited result has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_GROUPS_IN_USE:    cfg_groups = value[GIU_W-1:0];
      REG_BITS_PER_BITMAP:  cfg_bits   = value[NBITS_W-1:0];
      REG_BLOCKS_PER_GROUP: cfg_stride = value[BPG_W-1:0];
      default:              cfg_offset = value[0];
    endcase
    @(posedge clk);
  endtask

  task automatic reconfigure(input int groups, input int bits, input int stride,
                             input int offset);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_GROUPS_IN_USE, groups);
    write_reg(REG_BITS_PER_BITMAP, bits);
    write_reg(REG_BLOCKS_PER_GROUP, stride);
    write_reg(REG_FIRST_DATA_BLOCK, offset);
  endtask

  // Bitmap word: full with probability full_pct, else sparse or dense in clear bits
  function automatic logic [63:0] bitmap_word_value();
    logic [63:0] w;
    w = {$urandom, $urandom};
    if ($urandom_range(99) < full_pct) return '1;
    case ($urandom_range(2))
      0:       return w;
      1:       return ~(w & {$urandom, $urandom} & {$urandom, $urandom});
      default: return ~(64'd1 << $urandom_range(63));
    endcase
  endfunction

  function automatic logic [63:0] group_count_value();
    case ($urandom_range(9))
      0:       return 64'd0;
      1:       return {$urandom, $urandom};
      default: return 64'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [63:0] total_count_value();
    case ($urandom_range(3))
      0:       return 64'($urandom_range(0, 3));
      1:       return {$urandom, $urandom};
      default: return 64'($urandom_range(50, 5000));
    endcase
  endfunction

  // Load whatever the scan would read unloaded, then request an allocation
  task automatic allocate_block();
    int fg, fpos, gg, gw;
    while (first_fit(fg, fpos, gg, gw) == FIT_UNLOADED) begin
      if (gw < 0)
        send_request(KIND_LOAD_GROUP, gg, $urandom_range(127), group_count_value());
      else
        send_request(KIND_LOAD_WORD, gg, gw, bitmap_word_value());
    end
    send_request(KIND_ALLOCATE, $urandom_range(15), $urandom_range(127),
                 {$urandom, $urandom});
  endtask

  // One register setting followed by a random request mix
  task automatic run_phase(input int groups, input int bits, input int stride,
                           input int offset, input int fullp, input int items);
    int stop_at, ng, g, k, pick;
    reconfigure(groups, bits, stride, offset);
    full_pct = fullp;
    stop_at  = items_sent + items;
    ng = (groups > MAP_GROUPS) ? MAP_GROUPS : ((groups < 1) ? 1 : groups);
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        allocate_block();
      end else if (pick < 62) begin
        send_request(KIND_LOAD_WORD, $urandom_range(15), $urandom_range(127),
                     bitmap_word_value());
      end else if (pick < 70) begin
        send_request(KIND_LOAD_GROUP, $urandom_range(15), $urandom_range(127),
                     group_count_value());
      end else if (pick < 75) begin
        send_request(KIND_LOAD_TOTAL, $urandom_range(15), $urandom_range(127),
                     total_count_value());
      end else if (pick < 77) begin
        drain_results();
      end else begin
        // refill a scanned group: fresh counter then its leading words
        g = $urandom_range(ng - 1);
        k = $urandom_range(3);
        send_request(KIND_LOAD_GROUP, g, $urandom_range(127), 64'($urandom_range(1, 6)));
        for (int w = 0; w <= k; w++)
          send_request(KIND_LOAD_WORD, g, w, bitmap_word_value());
      end
    end
  endtask

  // Counter truncation, zero-counter skip, full group with nonzero counter,
  // partial last word, total counter saturating at zero, field extremes
  task automatic test_load_and_first_fit();
    reconfigure(3, 100, 16383, 1);
    send_request(KIND_LOAD_TOTAL, 0, 0, '1);
    send_request(KIND_LOAD_GROUP, 0, 0, 64'hFFFF_FFFF_FFFF_C000);
    send_request(KIND_LOAD_GROUP, 1, 0, 64'd2);
    send_request(KIND_LOAD_WORD, 1, 0, '1);
    send_request(KIND_LOAD_WORD, 1, 1, 64'h0000_000F_FFFF_FFFF);
    send_request(KIND_LOAD_GROUP, 2, 0, 64'd1);
    send_request(KIND_LOAD_WORD, 2, 0, 64'h7FFF_FFFF_FFFF_FFFF);
    allocate_block();
    allocate_block();
    send_request(KIND_LOAD_TOTAL, 15, 127, 64'd0);
    send_request(KIND_LOAD_GROUP, 2, 0, 64'h3FFF);
    send_request(KIND_LOAD_WORD, 2, 1, 64'd0);
    allocate_block();
    send_request(KIND_LOAD_WORD, 15, 127, {$urandom, $urandom});
    send_request(KIND_LOAD_GROUP, 15, 127, {$urandom, $urandom});
    send_request(KIND_LOAD_WORD, 0, 0, 64'd0);
  endtask

  // Zero groups and zero bitmap bits scan nothing; then a block number of zero
  task automatic test_empty_scan();
    reconfigure(0, 0, 1, 0);
    allocate_block();
    reconfigure(1, 0, 1, 0);
    send_request(KIND_LOAD_GROUP, 0, 0, 64'd1);
    allocate_block();
    reconfigure(1, 64, 1, 0);
    allocate_block();
  endtask

  task automatic test_default_geometry();
    run_phase(16, 8192, 8192, 1, 90, 130);
  endtask

  task automatic test_single_group();
    run_phase(1, 64, 1, 0, 20, 110);
  endtask

  task automatic test_saturated_registers();
    run_phase(31, 16383, 16383, 1, 95, 130);
  endtask

  task automatic test_odd_sizes();
    run_phase(5, 100, 100, 0, 50, 110);
  endtask

  task automatic test_random_geometry();
    repeat (2)
      run_phase($urandom_range(1, 16), $urandom_range(64, 512), $urandom_range(1, 16383),
                $urandom_range(1), $urandom_range(30, 90), 100);
  endtask

  task automatic test_back_to_back();
    steady = 1'b1;
    run_phase(8, 256, 256, 1, 60, 100);
    steady = 1'b0;
  endtask

  // Result checker: handshake seen at the falling edge completes at the next rising edge
  always @(negedge clk) begin : check_results
    alloc_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_results.size() == 0) begin
        flag_error($sformatf("unexpected result: status %0d block %0d free %0d",
                             m_tuser[0], m_tdata[17:0], m_tdata[35:18]));
      end else begin
        want = awaited_results.pop_front();
        if (m_tuser[0] !== want.status || m_tdata[17:0] !== want.block ||
            m_tdata[35:18] !== want.free_left)
          flag_error($sformatf({"expected status %0d block %0d free %0d, ",
                                "got status %0d block %0d free %0d"},
                               want.status, want.block, want.free_left,
                               m_tuser[0], m_tdata[17:0], m_tdata[35:18]));
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(negedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random stalls except during the steady stretch
  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= 10);
  end

  initial begin
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    m_tready = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    rst      = 1'b1;
    map_loaded = '{default: 1'b0};
    grp_loaded = '{default: 1'b0};
    free_total = '0;
    cfg_groups = GIU_RESET;
    cfg_bits   = NBITS_RESET;
    cfg_stride = BPG_RESET;
    cfg_offset = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_load_and_first_fit();
    test_empty_scan();
    test_default_geometry();
    test_single_group();
    test_saturated_registers();
    test_odd_sizes();
    test_random_geometry();
    test_back_to_back();

    drain_results();
    repeat (SETTLE_CYCLES * 4) @(posedge clk);
    if (error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

>>> sim.f
src/gbba_pkg.sv
src/group_bitmap_block_allocator.sv
sim/group_bitmap_block_allocator_tb.sv
